// File: hdl/dlsc_pkg.sv
package dlsc_pkg;

   localparam int DEFAULT_MAX_LIGHTS = 32;
   localparam int MASK_W = 32;
   localparam int IDX_W  = 5;
   localparam int CMD_W  = 3;
   localparam int CNT_W  = 6;

   localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_FACE  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_GRID  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_TRI   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_OTHER = 3'd4;

   typedef struct packed {
      logic signed [31:0] org_x;
      logic signed [31:0] org_y;
      logic signed [31:0] org_z;
      logic signed [31:0] radius;
   } light_type;

   // normal/minimum in first, grid maximum in second, plane distance in scalar
   typedef struct packed {
      logic signed [31:0] first_x;
      logic signed [31:0] first_y;
      logic signed [31:0] first_z;
      logic signed [31:0] second_x;
      logic signed [31:0] second_y;
      logic signed [31:0] second_z;
      logic signed [31:0] scalar;
   } surf_type;

   typedef struct packed {
      logic             active;
      logic             valid;
      logic [IDX_W-1:0] idx;
      logic             drop;
   } pipe_stat_type;

   function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
      return {v[31], v};
   endfunction

endpackage

// File: hdl/dynamic_light_surface_cull_top.sv
// Channel   Ports                          Handshake
// request   req_*                          taken when start is high and busy low
// response  rsp_mask_out, rsp_all_culled   rsp_valid high for one cycle
// config    csr_wr_data                    written when csr_wr_en is high
//
// A light load is written to the table in its accept cycle; busy stays low.
// Triangle and other surfaces answer in the cycle after accept.
// Face and grid tests read one light per cycle from the table memory and run
// it through a four-stage test pipe, for count = min(light_count, MAX_LIGHTS)
// lights; busy stays high until the pipe has drained. Reset is synchronous and
// clears control state only; the light table holds no reset value. Results
// cannot be stalled by the receiver.
module dynamic_light_surface_cull_top #(
   parameter int MAX_LIGHTS = dlsc_pkg::DEFAULT_MAX_LIGHTS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [dlsc_pkg::CMD_W-1:0]         req_cmd,
   input  logic [dlsc_pkg::IDX_W-1:0]         req_light_slot,
   input  logic signed [31:0]                 req_first_x,
   input  logic signed [31:0]                 req_first_y,
   input  logic signed [31:0]                 req_first_z,
   input  logic signed [31:0]                 req_second_x,
   input  logic signed [31:0]                 req_second_y,
   input  logic signed [31:0]                 req_second_z,
   input  logic signed [31:0]                 req_scalar_value,
   input  logic [dlsc_pkg::MASK_W-1:0]        req_mask_in,
   output logic                               rsp_valid,
   output logic [dlsc_pkg::MASK_W-1:0]        rsp_mask_out,
   output logic                               rsp_all_culled,
   input  logic                               csr_wr_en,
   input  logic [dlsc_pkg::CNT_W-1:0]         csr_wr_data
);

   localparam int AW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
   localparam logic [dlsc_pkg::CNT_W-1:0] MAX_CNT = dlsc_pkg::CNT_W'(MAX_LIGHTS);

   logic                          accept;
   logic [dlsc_pkg::CNT_W-1:0]    light_count_ff;
   logic [dlsc_pkg::CNT_W-1:0]    count_in;
   logic [dlsc_pkg::CNT_W-1:0]    count_ff;
   logic [dlsc_pkg::CNT_W-1:0]    iss_ff;
   logic                          run_ff;
   logic                          face_ff;
   logic                          rd_valid_ff;
   logic [dlsc_pkg::IDX_W-1:0]    rd_idx_ff;
   logic                          issue;
   logic                          done;
   logic [dlsc_pkg::MASK_W-1:0]   mask_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [dlsc_pkg::MASK_W-1:0]   rsp_mask_ff;
   dlsc_pkg::surf_type            surf_ff;
   dlsc_pkg::light_type           wr_light;
   dlsc_pkg::light_type           rd_light;
   logic                          wr_en;
   dlsc_pkg::pipe_stat_type       pstat;

   assign accept   = start & ~run_ff;
   assign busy     = run_ff;
   assign count_in = (light_count_ff > MAX_CNT) ? MAX_CNT : light_count_ff;
   assign issue    = run_ff && (iss_ff < count_ff);
   assign done     = run_ff && !issue && !rd_valid_ff && !pstat.active;

   assign wr_en = accept && (req_cmd == dlsc_pkg::CMD_LOAD)
                  && ({1'b0, req_light_slot} < MAX_CNT);
   assign wr_light.org_x  = req_first_x;
   assign wr_light.org_y  = req_first_y;
   assign wr_light.org_z  = req_first_z;
   assign wr_light.radius = req_scalar_value;

   dlsc_light_mem #(
      .DEPTH (MAX_LIGHTS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_light_slot[AW-1:0]),
      .wr_data (wr_light),
      .rd_addr (iss_ff[AW-1:0]),
      .rd_data (rd_light)
   );

   dlsc_test_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_valid_ff),
      .in_idx    (rd_idx_ff),
      .light     (rd_light),
      .surf      (surf_ff),
      .face_mode (face_ff),
      .stat      (pstat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         light_count_ff <= '0;
      end else if (csr_wr_en) begin
         light_count_ff <= csr_wr_data;
      end
   end

   // answer at once for every surface that needs no table walk
   always_comb begin
      rsp_valid_in = done;
      if (accept) begin
         case (req_cmd)
            dlsc_pkg::CMD_LOAD, dlsc_pkg::CMD_FACE, dlsc_pkg::CMD_GRID: begin
               rsp_valid_in = 1'b0;
            end
            default: begin
               rsp_valid_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         iss_ff       <= '0;
      end else begin
         rd_valid_ff  <= issue;
         rsp_valid_ff <= rsp_valid_in;
         if (issue) begin
            iss_ff <= iss_ff + 1'b1;
         end
         if (done) begin
            run_ff <= 1'b0;
         end
         if (accept && (req_cmd inside {dlsc_pkg::CMD_FACE, dlsc_pkg::CMD_GRID})) begin
            run_ff <= 1'b1;
            iss_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= iss_ff[dlsc_pkg::IDX_W-1:0];
      if (pstat.valid && pstat.drop) begin
         mask_ff[pstat.idx] <= 1'b0;
      end
      if (done) begin
         rsp_mask_ff <= mask_ff;
      end
      if (accept) begin
         count_ff         <= count_in;
         face_ff          <= (req_cmd == dlsc_pkg::CMD_FACE);
         mask_ff          <= req_mask_in;
         surf_ff.first_x  <= req_first_x;
         surf_ff.first_y  <= req_first_y;
         surf_ff.first_z  <= req_first_z;
         surf_ff.second_x <= req_second_x;
         surf_ff.second_y <= req_second_y;
         surf_ff.second_z <= req_second_z;
         surf_ff.scalar   <= req_scalar_value;
         case (req_cmd)
            dlsc_pkg::CMD_TRI: begin
               rsp_mask_ff <= req_mask_in;
            end
            dlsc_pkg::CMD_LOAD, dlsc_pkg::CMD_FACE, dlsc_pkg::CMD_GRID: begin
               rsp_mask_ff <= rsp_mask_ff;
            end
            default: begin
               rsp_mask_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mask_out   = rsp_mask_ff;
   assign rsp_all_culled = (rsp_mask_ff == '0);

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while a test is running");

   a_iss_bound: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> (iss_ff <= count_ff))
      else $error("issue index passed the light count");

   a_pipe_in_run: assert property (@(posedge clock) disable iff (reset)
      pstat.valid |-> run_ff)
      else $error("test verdict outside a running test");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == dlsc_pkg::CMD_LOAD) |=> !rsp_valid)
      else $error("light load produced a result");

   a_done_drained: assert property (@(posedge clock) disable iff (reset)
      done |-> (!pstat.valid && iss_ff == count_ff))
      else $error("result taken before the pipe drained");

endmodule

// File: hdl/dlsc_light_mem.sv
module dlsc_light_mem #(
   parameter int DEPTH = dlsc_pkg::DEFAULT_MAX_LIGHTS,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  dlsc_pkg::light_type   wr_data,
   input  logic [AW-1:0]         rd_addr,
   output dlsc_pkg::light_type   rd_data
);

   dlsc_pkg::light_type mem [DEPTH];
   dlsc_pkg::light_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/dlsc_test_pipe.sv
module dlsc_test_pipe (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [dlsc_pkg::IDX_W-1:0]        in_idx,
   input  dlsc_pkg::light_type               light,
   input  dlsc_pkg::surf_type                surf,
   input  logic                              face_mode,
   output dlsc_pkg::pipe_stat_type           stat
);

   // stage 1: products and grid box test
   logic                       v1_ff;
   logic [dlsc_pkg::IDX_W-1:0] idx1_ff;
   logic signed [63:0]         px_ff, py_ff, pz_ff;
   logic signed [63:0]         px_in, py_in, pz_in;
   logic signed [31:0]         r1_ff;
   logic                       gdrop1_ff;
   logic                       gdrop1_in;

   // stage 2: partial sums
   logic                       v2_ff;
   logic [dlsc_pkg::IDX_W-1:0] idx2_ff;
   logic signed [64:0]         sxy_ff, szd_ff;
   logic signed [64:0]         sxy_in, szd_in;
   logic signed [31:0]         r2_ff;
   logic                       gdrop2_ff;

   // stage 3: plane distance
   logic                       v3_ff;
   logic [dlsc_pkg::IDX_W-1:0] idx3_ff;
   logic signed [65:0]         d_ff;
   logic signed [65:0]         d_in;
   logic signed [31:0]         r3_ff;
   logic                       gdrop3_ff;

   // stage 4: verdict
   logic                       v4_ff;
   logic [dlsc_pkg::IDX_W-1:0] idx4_ff;
   logic                       drop4_ff;
   logic                       drop4_in;
   logic signed [65:0]         r66;

   always_comb begin
      logic signed [31:0] org [3];
      logic signed [31:0] mn [3];
      logic signed [31:0] mx [3];
      logic signed [32:0] lo, hi;
      org[0] = light.org_x;
      org[1] = light.org_y;
      org[2] = light.org_z;
      mn[0]  = surf.first_x;
      mn[1]  = surf.first_y;
      mn[2]  = surf.first_z;
      mx[0]  = surf.second_x;
      mx[1]  = surf.second_y;
      mx[2]  = surf.second_z;
      gdrop1_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         lo = dlsc_pkg::sx33(org[k]) - dlsc_pkg::sx33(light.radius);
         hi = dlsc_pkg::sx33(org[k]) + dlsc_pkg::sx33(light.radius);
         if (lo > dlsc_pkg::sx33(mx[k]) || hi < dlsc_pkg::sx33(mn[k])) begin
            gdrop1_in = 1'b1;
         end
      end
      px_in = light.org_x * surf.first_x;
      py_in = light.org_y * surf.first_y;
      pz_in = light.org_z * surf.first_z;
   end

   assign sxy_in = {px_ff[63], px_ff} + {py_ff[63], py_ff};
   assign szd_in = {pz_ff[63], pz_ff}
                 - {{17{surf.scalar[31]}}, surf.scalar, 16'h0000};
   assign d_in   = {sxy_ff[64], sxy_ff} + {szd_ff[64], szd_ff};
   assign r66    = {{18{r3_ff[31]}}, r3_ff, 16'h0000};
   assign drop4_in = face_mode ? ((d_ff < -r66) || (d_ff > r66)) : gdrop3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff   <= in_idx;
      px_ff     <= px_in;
      py_ff     <= py_in;
      pz_ff     <= pz_in;
      r1_ff     <= light.radius;
      gdrop1_ff <= gdrop1_in;

      idx2_ff   <= idx1_ff;
      sxy_ff    <= sxy_in;
      szd_ff    <= szd_in;
      r2_ff     <= r1_ff;
      gdrop2_ff <= gdrop1_ff;

      idx3_ff   <= idx2_ff;
      d_ff      <= d_in;
      r3_ff     <= r2_ff;
      gdrop3_ff <= gdrop2_ff;

      idx4_ff   <= idx3_ff;
      drop4_ff  <= drop4_in;
   end

   assign stat.active = v1_ff | v2_ff | v3_ff | v4_ff;
   assign stat.valid  = v4_ff;
   assign stat.idx    = idx4_ff;
   assign stat.drop   = drop4_ff;

endmodule
